// ===== hw/rtl/totp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register indexes and saturation helpers for the trapezoid profile planner.
// No dependencies; the front, queue, back and top files of the block import this package.
package totp_pkg;

  localparam logic [1:0] CFG_VLIM = 2'd0;
  localparam logic [1:0] CFG_ALIM = 2'd1;
  localparam logic [1:0] CFG_TOL  = 2'd2;

  typedef struct packed {
    logic [30:0] vm;
    logic [30:0] am;
    logic [15:0] eps;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] x1;
    logic signed [31:0] v0c;
    logic signed [31:0] v1c;
    logic signed [32:0] d;
    logic signed [32:0] dv;
    logic [32:0]        dabs;
    logic [32:0]        dvabs;
    logic               dvsmall;
    logic               still;
    logic               infeas;
  } req_t;

  function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] sat_u32(input logic [63:0] v);
    logic [31:0] r;
    if (|v[63:32]) r = 32'hFFFF_FFFF;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/totp_front.sv =====
`timescale 1ns / 1ps
// Front part: configuration registers, request acceptance and classification.
// Depends on totp_pkg; feeds classified requests into totp_queue.
module totp_front import totp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic [31:0] start_pos,
  input  logic [31:0] end_pos,
  input  logic [31:0] start_vel,
  input  logic [31:0] end_vel,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        q_full,
  output logic        q_push,
  output req_t        q_data,
  output cfg_t        cfg
);

  logic [30:0] vlim;
  logic [30:0] alim;
  logic [15:0] tol;
  logic signed [31:0] vm_s;
  logic signed [32:0] vm_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vlim <= 31'd65536;
      alim <= 31'd65536;
      tol  <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_VLIM: vlim <= cfg_data;
        CFG_ALIM: alim <= cfg_data;
        CFG_TOL:  tol  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg.vm  = (vlim == 31'd0) ? 31'd1 : vlim;
  assign cfg.am  = (alim == 31'd0) ? 31'd1 : alim;
  assign cfg.eps = tol;

  assign vm_s   = $signed({1'b0, cfg.vm});
  assign vm_neg = -$signed({2'b00, cfg.vm});

  always_comb begin
    q_data.x0  = $signed(start_pos);
    q_data.x1  = $signed(end_pos);
    q_data.v0c = ($signed(start_vel) > vm_s) ? vm_s : $signed(start_vel);
    q_data.v1c = ($signed(end_vel) > vm_s) ? vm_s : $signed(end_vel);
    q_data.d   = $signed({end_pos[31], end_pos}) - $signed({start_pos[31], start_pos});
    q_data.dv  = $signed({q_data.v1c[31], q_data.v1c}) - $signed({q_data.v0c[31], q_data.v0c});
    q_data.dabs  = q_data.d[32] ? 33'(-q_data.d) : 33'(q_data.d);
    q_data.dvabs = q_data.dv[32] ? 33'(-q_data.dv) : 33'(q_data.dv);
    q_data.dvsmall = q_data.dvabs < {17'd0, cfg.eps};
    q_data.still   = q_data.dvsmall && (q_data.dabs < {17'd0, cfg.eps});
    q_data.infeas  = ($signed({q_data.v0c[31], q_data.v0c}) < vm_neg) ||
                     ($signed({q_data.v1c[31], q_data.v1c}) < vm_neg);
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== hw/rtl/totp_queue.sv =====
`timescale 1ns / 1ps
// Two-entry request queue between the front and back parts.
// Depends on totp_pkg for the request type.
module totp_queue import totp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_data,
  output logic full,
  input  logic pop,
  output req_t pop_data,
  output logic empty
);

  req_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full     = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

endmodule

// ===== hw/rtl/totp_div.sv =====
`timescale 1ns / 1ps
// Radix-2 restoring divider: 64-bit dividend by 33-bit divisor, one quotient bit a cycle.
// No dependencies; used by totp_back.
module totp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [32:0] rem;
  logic [32:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] sh;

  assign sh = {rem, quotient[63]};

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= 33'd0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (sh >= {1'b0, dvs}) begin
        rem <= 33'(sh - {1'b0, dvs});
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        rem <= sh[32:0];
        quotient <= {quotient[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/totp_sqrt.sv =====
`timescale 1ns / 1ps
// Digit-by-digit integer square root of a 64-bit value, one root bit a cycle.
// No dependencies; used by totp_back.
module totp_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] arg,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] a;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [35:0] sh;
  logic [35:0] trial;

  assign sh    = {rem, a[63:62]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (start) begin
      a    <= arg;
      rem  <= 34'd0;
      root <= 32'd0;
    end else if (busy) begin
      a <= {a[61:0], 2'b00};
      if (sh >= trial) begin
        rem  <= 34'(sh - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= sh[33:0];
        root <= {root[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/totp_back.sv =====
`timescale 1ns / 1ps
// Back part: sequencer that plans one request with a shared multiplier, divider and root unit.
// Depends on totp_pkg, totp_div and totp_sqrt; drives the segment output register.
module totp_back import totp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_empty,
  output logic        q_pop,
  input  req_t        q_data,
  output logic [31:0] seg_pos,
  output logic [31:0] seg_vel,
  output logic [31:0] seg_accel,
  output logic [31:0] seg_duration,
  output logic        status,
  output logic        last,
  output logic        out_valid,
  input  logic        out_stall
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MUL     = 4'd1;
  localparam logic [3:0] ST_DSTR    = 4'd2;
  localparam logic [3:0] ST_CHK     = 4'd3;
  localparam logic [3:0] ST_ARG     = 4'd4;
  localparam logic [3:0] ST_SQRT    = 4'd5;
  localparam logic [3:0] ST_MUL2    = 4'd6;
  localparam logic [3:0] ST_DIVGO   = 4'd7;
  localparam logic [3:0] ST_DIVWAIT = 4'd8;
  localparam logic [3:0] ST_EMIT    = 4'd9;

  localparam logic [2:0] J_DSTR   = 3'd0;
  localparam logic [2:0] J_STR    = 3'd1;
  localparam logic [2:0] J_Q      = 3'd2;
  localparam logic [2:0] J_CRUISE = 3'd3;
  localparam logic [2:0] J_DUR0   = 3'd4;
  localparam logic [2:0] J_RAMP0  = 3'd5;
  localparam logic [2:0] J_RAMP2  = 3'd6;
  localparam logic [2:0] J_DUR1   = 3'd7;

  localparam logic [2:0] K_STILL = 3'd0;
  localparam logic [2:0] K_STR   = 3'd1;
  localparam logic [2:0] K_INF   = 3'd2;
  localparam logic [2:0] K_TRI   = 3'd3;
  localparam logic [2:0] K_TRAP  = 3'd4;

  logic [3:0]  state;
  logic [1:0]  mstep;
  logic [2:0]  job;
  logic [2:0]  kind;
  logic [1:0]  segidx;
  req_t        rq;
  logic [63:0] sq0, sq1, term, vm2, pk2, arg, qv;
  logic signed [63:0] dstr, ramp0, ramp2;
  logic        sigma_neg;
  logic        div_neg;
  logic [31:0] mag;
  logic signed [33:0] vpk;
  logic signed [31:0] acc;
  logic [31:0] dur0, dur1, cruise;

  logic [32:0] ma, mb;
  logic [65:0] prod;
  logic [31:0] v0abs, v1abs;
  logic [32:0] am1, am2;

  logic signed [64:0] snum, snum_abs;
  logic signed [34:0] dvd0, dvd1;
  logic [32:0] dsor;
  logic        flip;
  logic        div_start, div_done;
  logic [63:0] div_q;
  logic signed [63:0] qs;
  logic [31:0] du;

  logic signed [64:0] diff, diff_abs;
  logic [64:0] hsum;
  logic [63:0] halfsum, arg_c;
  logic        add_case;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;

  logic        ld;
  logic [1:0]  nseg;
  logic        seg_last;
  logic signed [63:0] pos1, pos2;
  logic signed [31:0] s_pos, s_vel, s_acc;
  logic [31:0] s_dur;
  logic        s_status;

  assign am1   = {2'b00, cfg.am};
  assign am2   = {1'b0, cfg.am, 1'b0};
  assign v0abs = rq.v0c[31] ? 32'(-rq.v0c) : 32'(rq.v0c);
  assign v1abs = rq.v1c[31] ? 32'(-rq.v1c) : 32'(rq.v1c);

  always_comb begin
    ma = 33'd0;
    mb = 33'd0;
    if (state == ST_MUL2) begin
      ma = {1'b0, mag};
      mb = {1'b0, mag};
    end else begin
      case (mstep)
        2'd0: begin ma = {1'b0, v0abs}; mb = {1'b0, v0abs}; end
        2'd1: begin ma = {1'b0, v1abs}; mb = {1'b0, v1abs}; end
        2'd2: begin ma = am1; mb = rq.dabs; end
        default: begin ma = {2'b00, cfg.vm}; mb = {2'b00, cfg.vm}; end
      endcase
    end
    prod = ma * mb;
  end

  assign dvd0 = $signed({vpk[33], vpk}) - $signed({{3{rq.v0c[31]}}, rq.v0c});
  assign dvd1 = $signed({vpk[33], vpk}) - $signed({{3{rq.v1c[31]}}, rq.v1c});

  always_comb begin
    snum = 65'sd0;
    dsor = am1;
    flip = 1'b0;
    unique case (job)
      J_DSTR: begin
        snum = $signed({1'b0, sq1}) - $signed({1'b0, sq0});
        dsor = am2;
        flip = rq.dv[32];
      end
      J_STR: snum = $signed({16'd0, rq.dvabs, 16'd0});
      J_Q: begin
        snum = $signed({1'b0, 64'(arg - vm2)});
        dsor = {2'b00, cfg.vm};
      end
      J_CRUISE: snum = $signed({1'b0, qv[47:0], 16'd0});
      J_DUR0: begin
        snum = $signed({{14{dvd0[34]}}, dvd0, 16'd0});
        flip = sigma_neg;
      end
      J_RAMP0: begin
        snum = $signed({1'b0, pk2}) - $signed({1'b0, sq0});
        dsor = am2;
        flip = sigma_neg;
      end
      J_RAMP2: begin
        snum = $signed({1'b0, sq1}) - $signed({1'b0, vm2});
        dsor = am2;
        flip = !sigma_neg;
      end
      J_DUR1: begin
        snum = $signed({{14{dvd1[34]}}, dvd1, 16'd0});
        flip = sigma_neg;
      end
      default: ;
    endcase
    snum_abs = snum[64] ? -snum : snum;
  end

  assign div_start = (state == ST_DIVGO);
  assign qs = div_neg ? -$signed(div_q) : $signed(div_q);
  assign du = div_neg ? 32'd0 : sat_u32(div_q);

  totp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (snum_abs[63:0]),
    .divisor  (dsor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign diff     = $signed({{32{rq.d[32]}}, rq.d}) - $signed({dstr[63], dstr});
  assign diff_abs = diff[64] ? -diff : diff;

  assign hsum     = {1'b0, sq0} + {1'b0, sq1};
  assign halfsum  = hsum[64:1];
  assign add_case = (rq.d == 33'sd0) || ((rq.d > 33'sd0) == !sigma_neg);
  assign arg_c    = add_case ? 64'(halfsum + term) :
                    ((halfsum > term) ? 64'(halfsum - term) : 64'd0);
  assign sq_start = (state == ST_ARG);

  totp_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .arg   (arg_c),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign q_pop = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      mstep  <= 2'd0;
      job    <= J_DSTR;
      kind   <= K_STILL;
      segidx <= 2'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            rq     <= q_data;
            segidx <= 2'd0;
            mstep  <= 2'd0;
            if (q_data.still) begin
              kind  <= K_STILL;
              state <= ST_EMIT;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          case (mstep)
            2'd0: sq0 <= prod[63:0];
            2'd1: sq1 <= prod[63:0];
            2'd2: term <= prod[63:0];
            default: vm2 <= prod[63:0];
          endcase
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) state <= ST_DSTR;
        end
        ST_DSTR: begin
          if (rq.dvsmall) begin
            dstr  <= 64'sd0;
            state <= ST_CHK;
          end else begin
            job   <= J_DSTR;
            state <= ST_DIVGO;
          end
        end
        ST_CHK: begin
          if (diff_abs <= $signed({49'd0, cfg.eps})) begin
            kind  <= K_STR;
            acc   <= rq.dv[32] ? -$signed({1'b0, cfg.am}) : $signed({1'b0, cfg.am});
            job   <= J_STR;
            state <= ST_DIVGO;
          end else begin
            sigma_neg <= !($signed({{31{rq.d[32]}}, rq.d}) > dstr);
            state     <= ST_ARG;
          end
        end
        ST_ARG: begin
          arg   <= arg_c;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_done) begin
            mag <= sq_root;
            acc <= sigma_neg ? -$signed({1'b0, cfg.am}) : $signed({1'b0, cfg.am});
            if (rq.infeas) begin
              kind  <= K_INF;
              state <= ST_EMIT;
            end else if (sq_root < {1'b0, cfg.vm}) begin
              kind  <= K_TRI;
              vpk   <= sigma_neg ? -$signed({2'b00, sq_root}) : $signed({2'b00, sq_root});
              state <= ST_MUL2;
            end else begin
              kind  <= K_TRAP;
              vpk   <= sigma_neg ? -$signed({3'b000, cfg.vm}) : $signed({3'b000, cfg.vm});
              pk2   <= vm2;
              job   <= J_Q;
              state <= ST_DIVGO;
            end
          end
        end
        ST_MUL2: begin
          pk2   <= prod[63:0];
          job   <= J_DUR0;
          state <= ST_DIVGO;
        end
        ST_DIVGO: begin
          div_neg <= snum[64] ^ flip;
          state   <= ST_DIVWAIT;
        end
        ST_DIVWAIT: begin
          if (div_done) begin
            state <= ST_DIVGO;
            unique case (job)
              J_DSTR: begin
                dstr  <= qs;
                state <= ST_CHK;
              end
              J_STR: begin
                dur0  <= du;
                state <= ST_EMIT;
              end
              J_Q: begin
                qv <= div_q;
                if (|div_q[63:47]) begin
                  cruise <= 32'hFFFF_FFFF;
                  job    <= J_DUR0;
                end else begin
                  job <= J_CRUISE;
                end
              end
              J_CRUISE: begin
                cruise <= sat_u32(div_q);
                job    <= J_DUR0;
              end
              J_DUR0: begin
                dur0 <= du;
                job  <= J_RAMP0;
              end
              J_RAMP0: begin
                ramp0 <= qs;
                job   <= (kind == K_TRAP) ? J_RAMP2 : J_DUR1;
              end
              J_RAMP2: begin
                ramp2 <= qs;
                job   <= J_DUR1;
              end
              J_DUR1: begin
                dur1  <= du;
                state <= ST_EMIT;
              end
              default: ;
            endcase
          end
        end
        ST_EMIT: begin
          if (ld) begin
            if (seg_last) state <= ST_IDLE;
            else segidx <= segidx + 2'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign nseg     = (kind == K_TRAP) ? 2'd3 : ((kind == K_TRI) ? 2'd2 : 2'd1);
  assign seg_last = (segidx == 2'(nseg - 2'd1));
  assign ld       = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign pos1     = $signed({{32{rq.x0[31]}}, rq.x0}) + ramp0;
  assign pos2     = $signed({{32{rq.x1[31]}}, rq.x1}) - ramp2;

  always_comb begin
    s_pos    = rq.x0;
    s_vel    = 32'sd0;
    s_acc    = 32'sd0;
    s_dur    = 32'd0;
    s_status = 1'b0;
    case (kind)
      K_INF: s_status = 1'b1;
      K_STR: begin
        s_vel = rq.v0c;
        s_acc = acc;
        s_dur = dur0;
      end
      K_TRI, K_TRAP: begin
        if (segidx == 2'd0) begin
          s_vel = rq.v0c;
          s_acc = acc;
          s_dur = dur0;
        end else if (segidx == 2'd1 && kind == K_TRAP) begin
          s_pos = sat_s32(pos1);
          s_vel = vpk[31:0];
          s_dur = cruise;
        end else if (segidx == 2'd1) begin
          s_pos = sat_s32(pos1);
          s_vel = vpk[31:0];
          s_acc = -acc;
          s_dur = dur1;
        end else begin
          s_pos = sat_s32(pos2);
          s_vel = vpk[31:0];
          s_acc = -acc;
          s_dur = dur1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      seg_pos      <= s_pos;
      seg_vel      <= s_vel;
      seg_accel    <= s_acc;
      seg_duration <= s_dur;
      status       <= s_status;
      last         <= seg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ld) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVWAIT)
    else $error("divider finished outside its wait state");

  a_sqrt_done_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == ST_SQRT)
    else $error("root unit finished outside its wait state");

  a_tri_two_segs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && kind == K_TRI) |-> segidx <= 2'd1)
    else $error("triangle profile produced more than two segments");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (ld && seg_last) |=> state == ST_IDLE && out_valid && last)
    else $error("final segment did not end the request");

endmodule

// ===== hw/rtl/time_optimal_trapezoid_profile.sv =====
`timescale 1ns / 1ps
// Minimum-time trapezoid planner: a request becomes one to three constant-acceleration segments.
// Up to seven divisions and at most one square root run in turn on shared units; the back part
// takes the next request in the cycle after the last segment loads. A two-entry queue takes
// requests meanwhile. Synchronous reset clears control state and restores the register defaults.
module time_optimal_trapezoid_profile import totp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic [31:0] start_pos,
  input  logic [31:0] end_pos,
  input  logic [31:0] start_vel,
  input  logic [31:0] end_vel,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [31:0] seg_pos,
  output logic [31:0] seg_vel,
  output logic [31:0] seg_accel,
  output logic [31:0] seg_duration,
  output logic        status,
  output logic        last,
  output logic        out_valid,
  input  logic        out_stall
);

  cfg_t cfg;
  req_t push_data;
  req_t pop_data;
  logic push, full, pop, empty;

  totp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start_pos (start_pos),
    .end_pos   (end_pos),
    .start_vel (start_vel),
    .end_vel   (end_vel),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .q_full    (full),
    .q_push    (push),
    .q_data    (push_data),
    .cfg       (cfg)
  );

  totp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  totp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (empty),
    .q_pop        (pop),
    .q_data       (pop_data),
    .seg_pos      (seg_pos),
    .seg_vel      (seg_vel),
    .seg_accel    (seg_accel),
    .seg_duration (seg_duration),
    .status       (status),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

endmodule

// ===== dv/trapezoid_checker.sv =====
`timescale 1ns / 1ps
// Checker for the trapezoid profile planner: it watches the register port and both channels,
// predicts the segments of each accepted request and compares them field by field.
// Depends on totp_pkg for the register indexes.
module trapezoid_checker import totp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic [31:0] start_pos,
  input  logic [31:0] end_pos,
  input  logic [31:0] start_vel,
  input  logic [31:0] end_vel,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] seg_pos,
  input  logic [31:0] seg_vel,
  input  logic [31:0] seg_accel,
  input  logic [31:0] seg_duration,
  input  logic        status,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_stall,
  output int          failures,
  output int          pending
);

  typedef struct {
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] accel;
    logic [31:0] dur;
    logic        st;
    logic        lst;
  } segment_t;

  localparam longint unsigned MASK32 = 64'hFFFF_FFFF;

  logic [30:0] vel_limit;
  logic [30:0] acc_limit;
  logic [15:0] tol;
  segment_t    expected_segs[$];

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] ramp_time(input longint dv, input longint a);
    longint q;
    q = (dv * 65536) / a;
    if (q < 0) return 32'd0;
    if (q > longint'(MASK32)) return 32'hFFFF_FFFF;
    return q[31:0];
  endfunction

  function automatic longint ramp_len(input longint vb, input longint va, input longint a);
    return (vb * vb - va * va) / (2 * a);
  endfunction

  function automatic segment_t make_seg(input longint p, input longint v, input longint a,
                                        input logic [31:0] t, input logic s, input logic l);
    segment_t g;
    g.pos = clip32(p);
    g.vel = clip32(v);
    g.accel = clip32(a);
    g.dur = t;
    g.st = s;
    g.lst = l;
    return g;
  endfunction

  task automatic queue_seg(input segment_t g);
    expected_segs = {expected_segs, g};
  endtask

  task automatic plan_motion(input logic [31:0] sp, input logic [31:0] ep,
                             input logic [31:0] sv, input logic [31:0] ev);
    longint x0, x1, v0, v1, vm, am, eps, d, dv, dstr, sg, a0, vp, vs, a;
    longint unsigned halfsum, term, arg, mg, num, q, cruise;
    logic [31:0] ctime;
    x0 = longint'(signed'(sp));
    x1 = longint'(signed'(ep));
    v0 = longint'(signed'(sv));
    v1 = longint'(signed'(ev));
    vm = vel_limit == 0 ? 1 : longint'(vel_limit);
    am = acc_limit == 0 ? 1 : longint'(acc_limit);
    eps = longint'(tol);
    if (v0 > vm) v0 = vm;
    if (v1 > vm) v1 = vm;
    d = x1 - x0;
    dv = v1 - v0;
    if (mag(dv) < eps && mag(d) < eps) begin
      queue_seg(make_seg(x0, 0, 0, 0, 0, 1));
      return;
    end
    if (mag(dv) < eps) dstr = 0;
    else if (dv > 0) dstr = (v1 * v1 - v0 * v0) / (2 * am);
    else dstr = -((v1 * v1 - v0 * v0) / (2 * am));
    if (mag(d - dstr) <= eps) begin
      a = dv < 0 ? -am : am;
      queue_seg(make_seg(x0, v0, a, ramp_time(dv, a), 0, 1));
      return;
    end
    sg = d > dstr ? 1 : -1;
    a0 = sg * am;
    halfsum = (longint'(v0 * v0) + longint'(v1 * v1)) >> 1;
    term = longint'(am) * longint'(mag(d));
    if (d == 0 || (d > 0) == (sg > 0)) arg = halfsum + term;
    else arg = halfsum > term ? halfsum - term : 0;
    mg = floor_root(arg);
    vp = sg * longint'(mg);
    if (mag(v0) > vm || mag(v1) > vm) begin
      queue_seg(make_seg(x0, 0, 0, 0, 1, 1));
      return;
    end
    if (longint'(mg) < vm) begin
      queue_seg(make_seg(x0, v0, a0, ramp_time(vp - v0, a0), 0, 0));
      queue_seg(make_seg(x0 + ramp_len(vp, v0, a0), vp, -a0,
                         ramp_time(vp - v1, a0), 0, 1));
    end else begin
      vs = sg * vm;
      num = arg - longint'(vm) * longint'(vm);
      q = num / longint'(vm);
      if (q >= (64'd1 << 47)) begin
        cruise = MASK32;
      end else begin
        cruise = (q * 65536) / longint'(am);
        if (cruise > MASK32) cruise = MASK32;
      end
      ctime = cruise[31:0];
      queue_seg(make_seg(x0, v0, a0, ramp_time(vs - v0, a0), 0, 0));
      queue_seg(make_seg(x0 + ramp_len(vs, v0, a0), vs, 0, ctime, 0, 0));
      queue_seg(make_seg(x1 - ramp_len(v1, vs, -a0), vs, -a0,
                         ramp_time(vs - v1, a0), 0, 1));
    end
  endtask

  always @(posedge clk) begin
    segment_t e;
    if (rst) begin
      vel_limit <= 31'd65536;
      acc_limit <= 31'd65536;
      tol <= 16'd1;
      failures <= 0;
      pending <= 0;
      expected_segs.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_VLIM: vel_limit <= cfg_data;
          CFG_ALIM: acc_limit <= cfg_data;
          CFG_TOL:  tol <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) plan_motion(start_pos, end_pos, start_vel, end_vel);
      if (out_valid && !out_stall) begin
        if (expected_segs.size() == 0) begin
          $error("segment with no request waiting");
          failures <= failures + 1;
        end else begin
          e = expected_segs.pop_front();
          if (seg_pos !== e.pos || seg_vel !== e.vel || seg_accel !== e.accel ||
              seg_duration !== e.dur || status !== e.st || last !== e.lst) begin
            failures <= failures + 1;
            if (seg_pos !== e.pos) $error("seg_pos expected %h actual %h", e.pos, seg_pos);
            if (seg_vel !== e.vel) $error("seg_vel expected %h actual %h", e.vel, seg_vel);
            if (seg_accel !== e.accel)
              $error("seg_accel expected %h actual %h", e.accel, seg_accel);
            if (seg_duration !== e.dur)
              $error("seg_duration expected %h actual %h", e.dur, seg_duration);
            if (status !== e.st) $error("status expected %b actual %b", e.st, status);
            if (last !== e.lst) $error("last expected %b actual %b", e.lst, last);
          end
        end
      end
      pending <= expected_segs.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the trapezoid planner testbench: clock, reset, register writes and request stimulus.
// Depends on totp_pkg, the planner RTL and trapezoid_checker, which does all comparison.
module testbench import totp_pkg::*;;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN = 800;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;
  logic [31:0] start_pos, end_pos, start_vel, end_vel;
  logic        in_valid, in_stall;
  logic [31:0] seg_pos, seg_vel, seg_accel, seg_duration;
  logic        status, last, out_valid, out_stall;
  int          failures, pending;
  int          cycles;
  logic        calm;
  logic        hold_req;
  longint      vlim, alim, tlim;

  time_optimal_trapezoid_profile uut (.*);
  trapezoid_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // The receiver stalls in random bursts, and once holds off long enough to back up the block.
  initial begin
    int n;
    bit held;
    held = 0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_stall = 1;
        for (n = 0; n < 4000; n++) @(negedge clk);
        held = 1;
        out_stall = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall = 1;
        n = $urandom_range(1, 17);
        repeat (n - 1) @(negedge clk);
        out_stall = 0;
      end else begin
        out_stall = 0;
        n = $urandom_range(1, 17);
        repeat (n - 1) begin
          @(negedge clk);
          if (hold_req && !held) break;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input longint val);
    @(negedge clk);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = val[30:0];
    @(negedge clk);
    cfg_write = 0;
    if (idx == CFG_VLIM) vlim = val == 0 ? 1 : val;
    if (idx == CFG_ALIM) alim = val == 0 ? 1 : val;
    if (idx == CFG_TOL) tlim = val;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_request(input longint sp, input longint ep, input longint sv,
                              input longint ev);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      repeat (gap) @(negedge clk);
    end
    start_pos = sp[31:0];
    end_pos = ep[31:0];
    start_vel = sv[31:0];
    end_vel = ev[31:0];
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 0;
  endtask

  function automatic longint rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic longint speed_near_limit();
    longint span;
    span = 2 * vlim + vlim / 4 + 1;
    return longint'(unsigned'(rand64()) % unsigned'(span)) - vlim;
  endfunction

  task automatic random_request();
    longint sp, ep, v0, v1, c0, c1, scale, travel;
    int pick;
    pick = $urandom_range(0, 9);
    sp = longint'(signed'($urandom));
    v0 = speed_near_limit();
    v1 = speed_near_limit();
    if (pick == 0) begin
      send_request(sp, longint'(signed'($urandom)), longint'(signed'($urandom)),
                   longint'(signed'($urandom)));
    end else if (pick == 1) begin
      travel = tlim > 0 ? $urandom_range(0, tlim) : 0;
      send_request(sp, sp + travel - tlim / 2, v0, v0 + $urandom_range(0, 1));
    end else if (pick == 2) begin
      c0 = v0 > vlim ? vlim : v0;
      c1 = v1 > vlim ? vlim : v1;
      travel = (c1 * c1 - c0 * c0) / (2 * alim);
      if (c1 < c0) travel = -travel;
      send_request(sp, sp + travel + $urandom_range(0, 2) - 1, v0, v1);
    end else begin
      scale = (vlim * vlim) / alim + 1;
      if (scale > 64'h4000_0000) scale = 64'h4000_0000;
      travel = longint'(unsigned'(rand64()) % unsigned'(6 * scale + 1)) - 3 * scale;
      send_request(sp, sp + travel, v0, v1);
    end
  endtask

  initial begin
    longint lims[4][3];
    int k, ph;
    rst = 1;
    calm = 0;
    hold_req = 0;
    cfg_write = 0;
    cfg_index = CFG_VLIM;
    cfg_data = 0;
    start_pos = 0;
    end_pos = 0;
    start_vel = 0;
    end_vel = 0;
    in_valid = 0;
    vlim = 65536;
    alim = 65536;
    tlim = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_request(0, 0, 0, 0);
    send_request(100, 100, 5, 5);
    send_request(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_request(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(0, 32768, 0, 65536);
    send_request(32768, 0, 65536, 0);
    send_request(0, -32768, 0, -65536);
    send_request(0, 0, 0, 65536);
    send_request(0, 1000, 0, 0);
    send_request(0, -1000, 0, 0);
    send_request(0, 65536, 0, 0);
    send_request(0, 10000000, 0, 0);
    send_request(0, -10000000, 20000, -30000);
    send_request(500, 900, -65537, 0);
    send_request(500, 900, 0, -70000);
    send_request(0, 200000, 80000, 90000);
    send_request(0, 65536, 65536, 65536);
    send_request(1234, 1234, 65536, 65536);
    send_request(-5000000, 5000000, -65536, 65536);
    wait_idle();

    lims[0] = '{65536, 65536, 1};
    lims[1] = '{1, 1, 0};
    lims[2] = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 65535};
    lims[3] = '{$urandom_range(1000, 2000000), $urandom_range(1000, 2000000),
                $urandom_range(0, 300)};
    for (ph = 0; ph < 4; ph++) begin
      write_reg(CFG_VLIM, lims[ph][0]);
      write_reg(CFG_ALIM, lims[ph][1]);
      write_reg(CFG_TOL, lims[ph][2]);
      if (ph == 1) begin
        send_request(0, 0, 0, 0);
        send_request(0, 0, 0, 1);
        send_request(0, 5, 0, 0);
      end
      if (ph == 0) hold_req = 1;
      for (k = 0; k < 70; k++) begin
        if (ph == 3 && k == 30) calm = 1;
        random_request();
      end
      wait_idle();
      calm = 0;
    end
    calm = 1;

    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
